### rtl/cfd_pkg.sv
// Shared types and constants of the command frame deframer.
// Used by the configuration registers, the parser, the top level and the checker.
`timescale 1ns / 1ps

package cfd_pkg;

  localparam int ByteW     = 8;
  localparam int CountW    = 11;
  localparam int CfgIdxW   = 2;
  localparam int EventW    = 2;

  // Number of payload bytes that follow a payload-carrying command.
  localparam int PayloadBytes = 1420;
  localparam logic [CountW-1:0] PayloadLast = CountW'(PayloadBytes);

  localparam logic [ByteW-1:0] CmdWithPayload = 8'h02;

  // Reset values of the configuration registers.
  localparam logic [ByteW-1:0] HeaderFirstRst   = 8'hAA;
  localparam logic [ByteW-1:0] HeaderSecondRst  = 8'h55;
  localparam logic [ByteW-1:0] TrailerFirstRst  = 8'h0D;
  localparam logic [ByteW-1:0] TrailerSecondRst = 8'h0A;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHeaderFirst   = 2'd0,
    CfgHeaderSecond  = 2'd1,
    CfgTrailerFirst  = 2'd2,
    CfgTrailerSecond = 2'd3
  } cfg_idx_e;

  typedef enum logic [EventW-1:0] {
    EvPayload = 2'd0,
    EvAccept  = 2'd1,
    EvDiscard = 2'd2
  } event_e;

  typedef struct packed {
    logic [ByteW-1:0] header_first;
    logic [ByteW-1:0] header_second;
    logic [ByteW-1:0] trailer_first;
    logic [ByteW-1:0] trailer_second;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    event_e            event_res;
    logic [ByteW-1:0]  out_byte;
    logic [CountW-1:0] byte_index;
  } res_t;

endpackage

### rtl/cfd_cfg_regs.sv
// Configuration register file of the command frame deframer.
// Depends on cfd_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module cfd_cfg_regs import cfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgHeaderFirst:   cfg_d.header_first   = cfg_wdata_i;
        CfgHeaderSecond:  cfg_d.header_second  = cfg_wdata_i;
        CfgTrailerFirst:  cfg_d.trailer_first  = cfg_wdata_i;
        CfgTrailerSecond: cfg_d.trailer_second = cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first   <= HeaderFirstRst;
      cfg_q.header_second  <= HeaderSecondRst;
      cfg_q.trailer_first  <= TrailerFirstRst;
      cfg_q.trailer_second <= TrailerSecondRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/cfd_parser.sv
// Frame parser state machine of the command frame deframer.
// Holds the parse phase, the command and the payload count; depends on cfd_pkg.
`timescale 1ns / 1ps

module cfd_parser import cfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  output res_t             res_o
);

  typedef enum logic [5:0] {
    PhHead1 = 6'b000001,
    PhHead2 = 6'b000010,
    PhCmd   = 6'b000100,
    PhData  = 6'b001000,
    PhTail1 = 6'b010000,
    PhTail2 = 6'b100000
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  cmd_q, cmd_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] count_inc;

  assign count_inc = count_q + CountW'(1);

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    count_d = count_q;
    res_o   = '{valid: 1'b0, event_res: EvPayload, out_byte: byte_i,
                byte_index: count_q};
    unique case (phase_q)
      PhHead2: begin
        if (byte_i == cfg_i.header_second) phase_d = PhCmd;
      end
      PhCmd: begin
        cmd_d   = byte_i;
        phase_d = (byte_i == CmdWithPayload) ? PhData : PhTail1;
      end
      PhData: begin
        res_o.valid = 1'b1;
        count_d     = count_inc;
        if (count_inc == PayloadLast) phase_d = PhTail1;
      end
      PhTail1: begin
        if (byte_i == cfg_i.trailer_first) phase_d = PhTail2;
      end
      PhTail2: begin
        res_o.valid      = 1'b1;
        res_o.event_res  = (byte_i == cfg_i.trailer_second) ? EvAccept : EvDiscard;
        res_o.out_byte   = cmd_q;
        res_o.byte_index = '0;
        phase_d          = PhHead1;
        cmd_d            = '0;
        count_d          = '0;
      end
      default: begin
        // Waiting for the first header; unreachable codes land here too.
        phase_d = (byte_i == cfg_i.header_first) ? PhHead2 : PhHead1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHead1;
      cmd_q   <= '0;
      count_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      count_q <= count_d;
    end
  end

endmodule

### rtl/command_frame_deframer_core.sv
// Top level of the command frame deframer: input register, parser, result register.
// Depends on cfd_pkg, cfd_cfg_regs and cfd_parser.
`timescale 1ns / 1ps

// The deframer takes one received byte per request and parses frames made of
// two header bytes, a command byte, a payload of PayloadBytes bytes (present
// only when the command is 0x02) and two trailer bytes. Each payload byte is
// delivered with its position in the payload as event 0. The byte after the
// first trailer byte always closes the frame: it yields event 1 (accepted)
// when it matches the second trailer register and event 2 (discarded)
// otherwise, both carrying the command byte and a zero index. A wrong second
// header or first trailer byte leaves the parser waiting in that phase. The
// block sustains one byte per cycle while the input is not stalled: a byte is
// held in the input register while the parser makes its single-step decision,
// and a result is then held in the output register until the sink takes it.
// A result is valid once its byte has passed the input register and been
// written into the output register. The input stalls only when a byte that
// produces a result finds the output register full and stalled.
// The four pattern registers are written through the configuration port and
// should only change while no frame bytes are in flight.

module command_frame_deframer_core import cfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  // Input byte channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   in_byte_i,
  // Result channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [EventW-1:0]  event_res_o,
  output logic [ByteW-1:0]   out_byte_o,
  output logic [CountW-1:0]  byte_index_o
);

  cfg_t cfg;
  res_t res;

  // Input register.
  logic             s1_valid_q, s1_valid_d;
  logic [ByteW-1:0] s1_byte_q;
  logic             in_accept;
  logic             out_free;
  logic             step;

  // Result register.
  logic              out_valid_q, out_valid_d;
  event_e            out_event_q;
  logic [ByteW-1:0]  out_byte_q;
  logic [CountW-1:0] out_index_q;

  cfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cfd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .byte_i (s1_byte_q),
    .res_o  (res)
  );

  // The output register can take a new result when it is empty or is being
  // drained this cycle. A byte that produces no result always moves on.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && (!res.valid || out_free);
  assign in_stall_o = s1_valid_q && !step;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (step) s1_valid_d = 1'b0;
    if (in_accept) s1_valid_d = 1'b1;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (step && res.valid) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) s1_byte_q <= in_byte_i;
    if (step && res.valid) begin
      out_event_q <= res.event_res;
      out_byte_q  <= res.out_byte;
      out_index_q <= res.byte_index;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_res_o  = out_event_q;
  assign out_byte_o   = out_byte_q;
  assign byte_index_o = out_index_q;

endmodule

### rtl/cfd_checker.sv
// Port-level assertions for the command frame deframer, bound to the top level.
// Depends on cfd_pkg and command_frame_deframer_core.
`timescale 1ns / 1ps

module cfd_checker import cfd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [EventW-1:0] event_res_o,
  input logic [ByteW-1:0]  out_byte_o,
  input logic [CountW-1:0] byte_index_o
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o) &&
    $stable(out_byte_o) && $stable(byte_index_o))
    else $error("stalled result changed");

  // The input only backs up behind a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> event_res_o == EvPayload || event_res_o == EvAccept ||
    event_res_o == EvDiscard)
    else $error("undefined event code");

  a_frame_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EvPayload |-> byte_index_o == '0)
    else $error("frame event with nonzero index");

  a_payload_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EvPayload |-> byte_index_o < PayloadLast)
    else $error("payload index out of range");

endmodule

bind command_frame_deframer_core cfd_checker u_cfd_checker (.*);

### tb/sv/cfd_frame_checker.sv
// Checker for the command frame deframer: watches the configuration port and both
// byte channels, predicts the frame events and compares them with the results.
// Depends on cfd_pkg.
`timescale 1ns / 1ps

module cfd_frame_checker import cfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [ByteW-1:0]   in_byte_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [EventW-1:0]  event_res_i,
  input  logic [ByteW-1:0]   out_byte_i,
  input  logic [CountW-1:0]  byte_index_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef enum logic [2:0] {
    HuntHdr1    = 3'd0,
    HuntHdr2    = 3'd1,
    TakeCmd     = 3'd2,
    TakePayload = 3'd3,
    HuntTrl1    = 3'd4,
    HuntTrl2    = 3'd5
  } parse_phase_e;

  typedef struct packed {
    event_e            ev;
    logic [ByteW-1:0]  data;
    logic [CountW-1:0] index;
  } frame_event_t;

  cfg_t              patterns;
  parse_phase_e      phase;
  logic [ByteW-1:0]  command;
  logic [CountW-1:0] payload_seen;
  frame_event_t      expected_events[$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: deframer check: %s", $time, msg);
    fail_count_o++;
  endtask

  // Advances the predicted parser by one received byte and queues the event it yields.
  task automatic parse_byte(input logic [ByteW-1:0] b);
    frame_event_t ev;
    case (phase)
      HuntHdr2: begin
        if (b == patterns.header_second) phase = TakeCmd;
      end
      TakeCmd: begin
        command = b;
        phase = (b == CmdWithPayload) ? TakePayload : HuntTrl1;
      end
      TakePayload: begin
        ev.ev    = EvPayload;
        ev.data  = b;
        ev.index = payload_seen;
        expected_events.push_back(ev);
        payload_seen = payload_seen + CountW'(1);
        if (payload_seen == PayloadLast) phase = HuntTrl1;
      end
      HuntTrl1: begin
        if (b == patterns.trailer_first) phase = HuntTrl2;
      end
      HuntTrl2: begin
        ev.ev    = (b == patterns.trailer_second) ? EvAccept : EvDiscard;
        ev.data  = command;
        ev.index = '0;
        expected_events.push_back(ev);
        phase        = HuntHdr1;
        command      = '0;
        payload_seen = '0;
      end
      default: begin
        phase = (b == patterns.header_first) ? HuntHdr2 : HuntHdr1;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    frame_event_t want;
    if (!rst_ni) begin
      patterns.header_first   = HeaderFirstRst;
      patterns.header_second  = HeaderSecondRst;
      patterns.trailer_first  = TrailerFirstRst;
      patterns.trailer_second = TrailerSecondRst;
      phase        = HuntHdr1;
      command      = '0;
      payload_seen = '0;
      expected_events.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgHeaderFirst:   patterns.header_first   = cfg_wdata_i;
          CfgHeaderSecond:  patterns.header_second  = cfg_wdata_i;
          CfgTrailerFirst:  patterns.trailer_first  = cfg_wdata_i;
          CfgTrailerSecond: patterns.trailer_second = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected result: event %0d byte %02h index %0d",
                                    event_res_i, out_byte_i, byte_index_i));
        end else begin
          want = expected_events.pop_front();
          if (event_res_i != want.ev)
            report_mismatch($sformatf("event %0d, expected %0d", event_res_i, want.ev));
          if (out_byte_i != want.data)
            report_mismatch($sformatf("byte %02h, expected %02h", out_byte_i, want.data));
          if (byte_index_i != want.index)
            report_mismatch($sformatf("index %0d, expected %0d", byte_index_i, want.index));
        end
      end
      if (in_valid_i && !in_stall_i) parse_byte(in_byte_i);
    end
    pending_o = expected_events.size();
  end

endmodule

### tb/sv/command_frame_deframer_core_tb.sv
// Testbench top of the command frame deframer: clock, reset, byte stimulus,
// pattern register writes and the final verdict.
// Depends on cfd_pkg, command_frame_deframer_core and cfd_frame_checker.
`timescale 1ns / 1ps

module command_frame_deframer_core_tb;
  import cfd_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [ByteW-1:0]   cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [ByteW-1:0]   in_byte;
  logic               out_valid;
  logic               out_stall;
  logic [EventW-1:0]  event_res;
  logic [ByteW-1:0]   out_byte;
  logic [CountW-1:0]  byte_index;

  int fail_count;
  int pending;

  // The stimulus keeps its own copy of the pattern registers so that it can build
  // frames that the parser will recognize under the current setting.
  logic [ByteW-1:0] hdr1;
  logic [ByteW-1:0] hdr2;
  logic [ByteW-1:0] trl1;
  logic [ByteW-1:0] trl2;

  int unsigned items_sent;
  bit          quiet_sender;

  always #5 clk = ~clk;

  command_frame_deframer_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_byte_i    (in_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .event_res_o  (event_res),
    .out_byte_o   (out_byte),
    .byte_index_o (byte_index)
  );

  cfd_frame_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_byte_i    (in_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .event_res_i  (event_res),
    .out_byte_i   (out_byte),
    .byte_index_i (byte_index),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Idle lengths for both channels: mostly none, often a few cycles, now and then
  // a long pause. A quiet stretch forces back-to-back traffic.
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [ByteW-1:0] byte_other_than(input logic [ByteW-1:0] v);
    logic [ByteW-1:0] b;
    do b = ByteW'($urandom_range(0, 255)); while (b == v);
    return b;
  endfunction

  // Lowers valid and holds the sender back until every predicted result has been
  // taken by the sink.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Offers one byte, possibly after an idle gap, and returns at the falling edge
  // after the request was taken. Every entry happens on a falling edge at which
  // valid was either just lowered or is about to carry the next byte, so the same
  // byte is never offered twice.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = pick_gap(quiet_sender);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
    // Occasionally the sender stops until the result side has run dry.
    if ($urandom_range(0, 199) == 0) drain_results();
  endtask

  // A frame under the current patterns. Wrong bytes can be placed where the parser
  // waits for the second header or the first trailer; the closing byte either
  // matches the second trailer or not.
  task automatic send_frame(input logic [ByteW-1:0] cmd, input int unsigned bad_h2,
                            input int unsigned bad_t1, input bit accept);
    send_byte(hdr1);
    repeat (bad_h2) send_byte(byte_other_than(hdr2));
    send_byte(hdr2);
    send_byte(cmd);
    if (cmd == CmdWithPayload) begin
      repeat (PayloadBytes) send_byte(ByteW'($urandom_range(0, 255)));
    end
    repeat (bad_t1) send_byte(byte_other_than(trl1));
    send_byte(trl1);
    send_byte(accept ? trl2 : byte_other_than(trl2));
  endtask

  // Pattern registers change only with the block idle: all results taken, and a
  // few more cycles for bytes that produce no result to leave the pipeline.
  task automatic write_patterns(input logic [ByteW-1:0] h1, input logic [ByteW-1:0] h2,
                                input logic [ByteW-1:0] t1, input logic [ByteW-1:0] t2);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgHeaderFirst;
    cfg_wdata <= h1;
    @(negedge clk);
    cfg_idx   <= CfgHeaderSecond;
    cfg_wdata <= h2;
    @(negedge clk);
    cfg_idx   <= CfgTrailerFirst;
    cfg_wdata <= t1;
    @(negedge clk);
    cfg_idx   <= CfgTrailerSecond;
    cfg_wdata <= t2;
    @(negedge clk);
    cfg_we <= 1'b0;
    hdr1 = h1;
    hdr2 = h2;
    trl1 = t1;
    trl2 = t2;
  endtask

  // Random frames and noise. Every sequence starts and ends with the parser
  // hunting for the first header: noise never contains that header byte, and a
  // frame always runs through to its closing byte. Commands stay off the payload
  // code here, since a payload frame alone costs well over a thousand requests.
  task automatic random_traffic(input int unsigned until_items);
    int unsigned pick;
    while (items_sent < until_items) begin
      quiet_sender = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_frame(byte_other_than(CmdWithPayload), 0, 0, $urandom_range(0, 3) != 0);
      end else if (pick < 60) begin
        send_frame(byte_other_than(CmdWithPayload), $urandom_range(1, 4), 0,
                   $urandom_range(0, 3) != 0);
      end else if (pick < 75) begin
        send_frame(byte_other_than(CmdWithPayload), $urandom_range(0, 2),
                   $urandom_range(1, 4), $urandom_range(0, 3) != 0);
      end else begin
        repeat ($urandom_range(1, 5)) send_byte(byte_other_than(hdr1));
      end
    end
    quiet_sender = 1'b0;
  endtask

  // The sink stalls in runs of random length, with long stall-free stretches
  // mixed in.
  initial begin : sink_pacing
    int unsigned stall_len;
    int unsigned free_len;
    out_stall = 1'b0;
    forever begin
      if ($urandom_range(0, 5) == 0) begin
        stall_len = 0;
        free_len  = $urandom_range(40, 160);
      end else begin
        stall_len = pick_gap(1'b0);
        free_len  = $urandom_range(1, 6);
      end
      @(negedge clk);
      if (stall_len != 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat (free_len - 1) @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [ByteW-1:0] same;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CfgHeaderFirst;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_byte      = '0;
    hdr1         = HeaderFirstRst;
    hdr2         = HeaderSecondRst;
    trl1         = TrailerFirstRst;
    trl2         = TrailerSecondRst;
    items_sent   = 0;
    quiet_sender = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames under the reset patterns. Two noise bytes with all bits low
    // and all bits high come first; then a clean accepted frame with command zero.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'h00, 0, 0, 1'b1);
    // A wrong second header byte, first one unrelated and then a repeated first
    // header byte, must leave the parser waiting rather than restart the hunt.
    // After command 0xFF two wrong first trailer bytes are ignored, and a closing
    // byte that misses the second trailer discards the frame.
    send_byte(hdr1);
    send_byte(8'h00);
    send_byte(hdr1);
    send_byte(hdr2);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(trl1);
    send_byte(8'hFF);
    send_frame(8'h01, 0, 0, 1'b1);

    // Random patterns, with the one full payload frame to walk the whole index
    // range, then random traffic.
    write_patterns(ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)),
                   ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)));
    send_frame(CmdWithPayload, $urandom_range(0, 1), $urandom_range(0, 1),
               $urandom_range(0, 1) != 0);
    random_traffic(1480);

    // Extreme pattern values, in both arrangements.
    write_patterns(8'h00, 8'hFF, 8'h00, 8'hFF);
    random_traffic(1570);
    write_patterns(8'hFF, 8'h00, 8'hFF, 8'h00);
    random_traffic(1660);

    // All four patterns equal, so header, trailer and noise bytes collide.
    same = ByteW'($urandom_range(0, 255));
    write_patterns(same, same, same, same);
    random_traffic(1760);

    drain_results();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("command_frame_deframer_core_tb OK");
    end else begin
      $display("command_frame_deframer_core_tb NOT OK");
    end
    $finish;
  end

  // A healthy run takes a small fraction of this, even with the longest stalls on
  // every request.
  initial begin : watchdog
    #6_000_000;
    $display("command_frame_deframer_core_tb NOT OK");
    $finish;
  end

endmodule
